// ===== rtl/deq_pkg.sv =====
// shared types, constants, micro-program and helpers for the double-ended queue
package deq_pkg;

    // queue geometry
    localparam int DEPTH  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = IDX_W + 1;

    // beat field widths
    localparam int OP_W   = 3;
    localparam int WORD_W = 32;
    localparam int ST_W   = 2;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [OP_W-1:0]          t_op;
    typedef logic [ST_W-1:0]          t_status;

    // operation codes
    localparam t_op OP_PUSH_FRONT = 3'd0;
    localparam t_op OP_PUSH_BACK  = 3'd1;
    localparam t_op OP_POP_FRONT  = 3'd2;
    localparam t_op OP_POP_BACK   = 3'd3;
    localparam t_op OP_DUMP       = 3'd4;

    // status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // micro-program addresses
    localparam int UPC_W = 3;
    typedef logic [UPC_W-1:0] t_upc;
    localparam t_upc UPC_FETCH  = 3'd0;
    localparam t_upc UPC_PUSH_F = 3'd1;
    localparam t_upc UPC_PUSH_B = 3'd2;
    localparam t_upc UPC_POP_F  = 3'd3;
    localparam t_upc UPC_POP_B  = 3'd4;
    localparam t_upc UPC_DUMP0  = 3'd5;
    localparam t_upc UPC_DUMP1  = 3'd6;

    // datapath action of a step
    typedef enum logic [2:0] {
        DP_NONE       = 3'd0,
        DP_PUSH_FRONT = 3'd1,
        DP_PUSH_BACK  = 3'd2,
        DP_POP_FRONT  = 3'd3,
        DP_POP_BACK   = 3'd4,
        DP_DUMP_START = 3'd5,
        DP_DUMP_NEXT  = 3'd6
    } t_dp;

    // result beat produced by a step
    typedef enum logic [1:0] {
        EM_NONE     = 2'd0,
        EM_STATUS   = 2'd1,
        EM_IF_EMPTY = 2'd2,
        EM_WORD     = 2'd3
    } t_emit;

    // jump condition
    typedef enum logic [1:0] {
        JC_ALWAYS   = 2'd0,
        JC_DISPATCH = 2'd1,
        JC_EMPTY    = 2'd2,
        JC_LAST     = 2'd3
    } t_jc;

    // control word
    typedef struct packed {
        logic  accept;
        logic  wait_slot;
        t_dp   dp;
        t_emit emit;
        t_jc   jc;
        t_upc  jmp;
        t_upc  alt;
    } t_uword;

    // condition flags into the sequencer
    typedef struct packed {
        logic in_valid;
        logic slot_free;
        logic empty;
        logic last;
        t_op  op;
    } t_seq_flags;

    // control out of the sequencer
    typedef struct packed {
        t_uword uw;
        logic   fire;
    } t_seq_ctrl;

    // micro-program store
    function automatic t_uword ucode_rom(t_upc a);
        t_uword w;
        w = '{accept: 1'b1, wait_slot: 1'b0, dp: DP_NONE, emit: EM_NONE,
              jc: JC_DISPATCH, jmp: UPC_FETCH, alt: UPC_FETCH};
        unique case (a)
            UPC_FETCH: ;
            UPC_PUSH_F: w = '{1'b0, 1'b1, DP_PUSH_FRONT, EM_STATUS, JC_ALWAYS,
                              UPC_FETCH, UPC_FETCH};
            UPC_PUSH_B: w = '{1'b0, 1'b1, DP_PUSH_BACK, EM_STATUS, JC_ALWAYS,
                              UPC_FETCH, UPC_FETCH};
            UPC_POP_F:  w = '{1'b0, 1'b1, DP_POP_FRONT, EM_STATUS, JC_ALWAYS,
                              UPC_FETCH, UPC_FETCH};
            UPC_POP_B:  w = '{1'b0, 1'b1, DP_POP_BACK, EM_STATUS, JC_ALWAYS,
                              UPC_FETCH, UPC_FETCH};
            UPC_DUMP0:  w = '{1'b0, 1'b1, DP_DUMP_START, EM_IF_EMPTY, JC_EMPTY,
                              UPC_FETCH, UPC_DUMP1};
            UPC_DUMP1:  w = '{1'b0, 1'b1, DP_DUMP_NEXT, EM_WORD, JC_LAST,
                              UPC_FETCH, UPC_DUMP1};
            default: ;
        endcase
        return w;
    endfunction

    // first step for each operation code
    function automatic t_upc op_dispatch(t_op op);
        t_upc a;
        a = UPC_FETCH;
        unique case (op)
            OP_PUSH_FRONT: a = UPC_PUSH_F;
            OP_PUSH_BACK:  a = UPC_PUSH_B;
            OP_POP_FRONT:  a = UPC_POP_F;
            OP_POP_BACK:   a = UPC_POP_B;
            OP_DUMP:       a = UPC_DUMP0;
            default:       a = UPC_FETCH;
        endcase
        return a;
    endfunction

    // ring index step forward
    function automatic t_idx idx_inc(t_idx a);
        return (a == IDX_W'(DEPTH - 1)) ? '0 : a + IDX_W'(1);
    endfunction

    // ring index step back
    function automatic t_idx idx_dec(t_idx a);
        return (a == '0) ? IDX_W'(DEPTH - 1) : a - IDX_W'(1);
    endfunction

endpackage

// ===== rtl/deq_if.sv =====
// valid/ready channel interfaces for the queue request and result beats
interface deq_in_if;
    logic                 valid;
    logic                 ready;
    deq_pkg::t_op         op;
    deq_pkg::t_word       value;

    modport source (output valid, op, value, input ready);
    modport sink   (input valid, op, value, output ready);
endinterface

interface deq_out_if;
    logic                 valid;
    logic                 ready;
    deq_pkg::t_word       word;
    deq_pkg::t_status     status;
    logic                 last_of_run;

    modport source (output valid, word, status, last_of_run, input ready);
    modport sink   (input valid, word, status, last_of_run, output ready);
endinterface

// ===== rtl/deq_ram.sv =====
// generic single-write, single-read ram with registered read data
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/deq_useq.sv =====
// micro-program sequencer: step counter, control store and jump logic
module deq_useq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  deq_pkg::t_seq_flags i_flags,
    output deq_pkg::t_seq_ctrl  o_ctrl
);

    deq_pkg::t_upc   r_upc;
    deq_pkg::t_upc   n_upc;
    deq_pkg::t_uword uw;
    logic            fire;

    // control word lookup
    assign uw = deq_pkg::ucode_rom(r_upc);

    // a step completes when its beat can move
    always_comb begin
        if (uw.accept) begin
            fire = i_flags.in_valid;
        end else begin
            fire = !uw.wait_slot || i_flags.slot_free;
        end
    end

    // next step selection
    always_comb begin
        n_upc = r_upc;
        if (fire) begin
            unique case (uw.jc)
                deq_pkg::JC_ALWAYS:   n_upc = uw.jmp;
                deq_pkg::JC_DISPATCH: n_upc = deq_pkg::op_dispatch(i_flags.op);
                deq_pkg::JC_EMPTY:    n_upc = i_flags.empty ? uw.jmp : uw.alt;
                deq_pkg::JC_LAST:     n_upc = i_flags.last ? uw.jmp : uw.alt;
                default:              n_upc = deq_pkg::UPC_FETCH;
            endcase
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= deq_pkg::UPC_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl.uw   = uw;
    assign o_ctrl.fire = fire;

    // a step waiting on the result slot stays put
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!uw.accept && uw.wait_slot && !i_flags.slot_free) |=> $stable(r_upc))
        else $error("step moved while result slot busy");

    // a push front request enters its step
    a_dispatch_pushf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == deq_pkg::UPC_FETCH && i_flags.in_valid
            && i_flags.op == deq_pkg::OP_PUSH_FRONT)
        |=> r_upc == deq_pkg::UPC_PUSH_F)
        else $error("push front not dispatched");

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// double-ended queue top level: ring store datapath driven by the micro-sequencer
// a request beat is taken only in the fetch step; its operation step then loads the status
//   into the result register, and a dump reads the ring store in its start step first
// no new request is taken until the operation step of the last one is through;
//   a dump takes one step per entry, set by the single read port of the ring store
// a busy result register stalls the sequencer until the beat is taken
// reset clears the step counter, front pointer, count and result valid; stored words stay
module double_ended_queue_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    deq_in_if.sink        i_in,
    deq_out_if.source     o_out
);

    deq_pkg::t_seq_flags flags;
    deq_pkg::t_seq_ctrl  ctrl;

    deq_pkg::t_idx    r_front, n_front;
    deq_pkg::t_cnt    r_count, n_count;
    deq_pkg::t_cnt    r_dump_left, n_dump_left;
    deq_pkg::t_idx    r_dump_addr, n_dump_addr;
    deq_pkg::t_word   r_val;

    logic             r_out_valid;
    deq_pkg::t_word   r_out_word;
    deq_pkg::t_status r_out_status;
    logic             r_out_last;

    logic                        slot_free, full, empty, last, is_push;
    logic                        we, re, emit, em_last;
    deq_pkg::t_idx               waddr, raddr, back_addr;
    logic [deq_pkg::SUM_W-1:0]   back_sum;
    logic [deq_pkg::WORD_W-1:0]  rdata;
    deq_pkg::t_word              em_word;
    deq_pkg::t_status            em_status;

    // queue condition flags
    assign slot_free = !r_out_valid || o_out.ready;
    assign full      = (r_count == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign empty     = (r_count == '0);
    assign last      = (r_dump_left == deq_pkg::CNT_W'(1));
    assign is_push   = (ctrl.uw.dp == deq_pkg::DP_PUSH_FRONT)
                    || (ctrl.uw.dp == deq_pkg::DP_PUSH_BACK);

    // back slot: front plus count, wrapped once
    assign back_sum  = {1'b0, r_front} + deq_pkg::SUM_W'(r_count);
    assign back_addr = (back_sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH))
                     ? deq_pkg::IDX_W'(back_sum - deq_pkg::SUM_W'(deq_pkg::DEPTH))
                     : deq_pkg::IDX_W'(back_sum);

    // sequencer
    always_comb begin
        flags.in_valid  = i_in.valid;
        flags.slot_free = slot_free;
        flags.empty     = empty;
        flags.last      = last;
        flags.op        = i_in.op;
    end

    deq_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    assign i_in.ready = ctrl.uw.accept;

    // ring store
    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (deq_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_val),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // datapath actions of the current step
    always_comb begin
        n_front     = r_front;
        n_count     = r_count;
        n_dump_left = r_dump_left;
        n_dump_addr = r_dump_addr;
        we          = 1'b0;
        waddr       = r_front;
        re          = 1'b0;
        raddr       = r_dump_addr;
        emit        = 1'b0;
        em_status   = deq_pkg::ST_OK;
        em_word     = '0;
        em_last     = 1'b1;
        if (ctrl.fire) begin
            unique case (ctrl.uw.dp)
                deq_pkg::DP_NONE: ;
                deq_pkg::DP_PUSH_FRONT: begin
                    if (!full) begin
                        n_front = deq_pkg::idx_dec(r_front);
                        we      = 1'b1;
                        waddr   = deq_pkg::idx_dec(r_front);
                        n_count = r_count + deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::DP_PUSH_BACK: begin
                    if (!full) begin
                        we      = 1'b1;
                        waddr   = back_addr;
                        n_count = r_count + deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::DP_POP_FRONT: begin
                    if (!empty) begin
                        n_front = deq_pkg::idx_inc(r_front);
                        n_count = r_count - deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::DP_POP_BACK: begin
                    if (!empty) begin
                        n_count = r_count - deq_pkg::CNT_W'(1);
                    end
                end
                deq_pkg::DP_DUMP_START: begin
                    if (!empty) begin
                        re          = 1'b1;
                        raddr       = r_front;
                        n_dump_addr = deq_pkg::idx_inc(r_front);
                        n_dump_left = r_count;
                    end
                end
                deq_pkg::DP_DUMP_NEXT: begin
                    re          = 1'b1;
                    raddr       = r_dump_addr;
                    n_dump_addr = deq_pkg::idx_inc(r_dump_addr);
                    n_dump_left = r_dump_left - deq_pkg::CNT_W'(1);
                end
                default: ;
            endcase
            unique case (ctrl.uw.emit)
                deq_pkg::EM_NONE: ;
                deq_pkg::EM_STATUS: begin
                    emit = 1'b1;
                    if (is_push) begin
                        em_status = full ? deq_pkg::ST_FULL : deq_pkg::ST_OK;
                    end else begin
                        em_status = empty ? deq_pkg::ST_EMPTY : deq_pkg::ST_OK;
                    end
                end
                deq_pkg::EM_IF_EMPTY: begin
                    emit      = empty;
                    em_status = deq_pkg::ST_EMPTY;
                end
                deq_pkg::EM_WORD: begin
                    emit    = 1'b1;
                    em_word = rdata;
                    em_last = last;
                end
                default: ;
            endcase
        end
    end

    // queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // dump walk and request word
    always_ff @(posedge i_clk) begin
        r_dump_left <= n_dump_left;
        r_dump_addr <= n_dump_addr;
        if (i_in.valid && i_in.ready) begin
            r_val <= i_in.value;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word   <= em_word;
            r_out_status <= em_status;
            r_out_last   <= em_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.word        = r_out_word;
    assign o_out.status      = r_out_status;
    assign o_out.last_of_run = r_out_last;

    // a beat is only loaded into a free result slot
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> slot_free)
        else $error("result beat overwrote a pending beat");

    // count stays within the ring
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
        else $error("entry count beyond depth");

    // an accepted push front grows the queue by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.fire && ctrl.uw.dp == deq_pkg::DP_PUSH_FRONT && !full)
        |=> r_count == $past(r_count) + deq_pkg::CNT_W'(1))
        else $error("push front did not add an entry");

endmodule
